// ===== rtl/pdv_pkg.sv =====
package pdv_pkg;

   localparam int KEY_MAX  = 16;
   localparam int NAME_MAX = 4096;

   // register map of the csr port
   typedef enum logic [2:0] {
      CSR_DECRYPT_ENABLE = 3'd0,
      CSR_KEY_LEN        = 3'd1,
      CSR_KEY_BYTES_LOW  = 3'd2,
      CSR_KEY_BYTES_HIGH = 3'd3,
      CSR_PAYLOAD_LEN    = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_DATA  = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_NAME    = 3'd0,
      KIND_SECRET  = 3'd1,
      KIND_EMPTY   = 3'd2,
      KIND_SHORT   = 3'd3,
      KIND_BADNAME = 3'd4,
      KIND_TRUNC   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_NAMELEN = 3'd1,
      PH_NAME    = 3'd2,
      PH_SECLEN  = 3'd3,
      PH_SECRET  = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/payload_deframer_vigenere.sv =====
// Length-prefixed payload deframer with repeating-key byte decryption.
//
// req channel: one beat per item; opcode start opens a new payload, opcode
// data delivers one raw payload byte. rsp channel: zero or one beat per
// item, carrying a filename byte or a secret byte (last marks the final byte of each),
// or a single status code (empty secret, short payload, bad name, truncated).
// csr channel: register writes by index, always ready; write only while the
// block holds no pending item.
//
// The result is registered: an item accepted at a clock edge shows its result at
// the rsp port after that edge. Throughput is one item per cycle, set by the
// single result register, which is refilled in the same cycle it drains.
// When the receiver stalls with a result held, req_ready drops until that
// beat is taken; items that produce no result are still held back then.
// Reset (synchronous, active high) clears the configuration, the parser state
// and the result valid, and puts the parser in idle, where data bytes are
// ignored until a start item.
module payload_deframer_vigenere
   import pdv_pkg::*;
#(
   parameter int NameMax = NAME_MAX
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [63:0]   csr_wdata
);

   localparam int NAME_W = $clog2(NameMax + 1);
   localparam int NL_W   = NAME_W + 4;
   localparam logic [4:0] KEY_LIMIT = 5'(KEY_MAX);

   // configuration
   logic          decrypt_enable_ff;
   logic [4:0]    key_len_ff;
   logic [127:0]  key_bytes_ff;
   logic [31:0]   payload_len_ff;

   // parser state
   phase_type     phase_ff, phase_in;
   logic [2:0]    byte_position_ff, byte_position_in;
   logic [63:0]   field_shift_ff, field_shift_in;
   logic [NAME_W-1:0] name_length_ff, name_length_in;
   logic [63:0]   bytes_left_ff, bytes_left_in;
   logic [3:0]    key_index_ff, key_index_in;

   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   logic          req_fire;
   logic          res_valid;
   rsp_type       res;

   // key stream
   logic [4:0]    key_eff_len;
   logic [3:0]    key_use;
   logic [4:0]    key_step;
   logic [3:0]    key_after;
   logic [7:0]    key_byte;
   logic [7:0]    plain;

   // length fields
   logic [63:0]   field_next;
   logic [31:0]   name_val;
   logic          name_bad;
   logic [NL_W-1:0] nl12;
   logic          pl_under;
   logic          sec_trunc;
   logic          active;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign active = (phase_ff == PH_NAMELEN) || (phase_ff == PH_NAME) ||
                   (phase_ff == PH_SECLEN) || (phase_ff == PH_SECRET);

   assign key_eff_len = (key_len_ff > KEY_LIMIT) ? KEY_LIMIT : key_len_ff;
   assign key_use     = ({1'b0, key_index_ff} >= key_eff_len) ? 4'd0 : key_index_ff;
   assign key_step    = {1'b0, key_use} + 5'd1;
   assign key_after   = (key_step >= key_eff_len) ? 4'd0 : key_step[3:0];
   assign key_byte    = (key_eff_len == 5'd0) ? 8'd0 : key_bytes_ff[{key_use, 3'b000} +: 8];
   assign plain       = decrypt_enable_ff ? (req_data.data_byte - key_byte)
                                          : req_data.data_byte;

   always_comb begin
      field_next = field_shift_ff;
      field_next[{byte_position_ff, 3'b000} +: 8] =
         field_shift_ff[{byte_position_ff, 3'b000} +: 8] | plain;
   end

   assign name_val = field_next[31:0];
   assign name_bad = (name_val == 32'd0) || (name_val > 32'(NameMax)) ||
                     (({1'b0, name_val} + 33'd12) > {1'b0, payload_len_ff});

   // 64-bit wrap of payload_len minus (name length + 12) folded into a 65-bit compare
   assign nl12      = NL_W'(name_length_ff) + NL_W'(12);
   assign pl_under  = payload_len_ff < 32'(nl12);
   assign sec_trunc = ({1'b0, field_next} + 65'(nl12)) > {pl_under, 32'd0, payload_len_ff};

   // next state
   always_comb begin
      phase_in         = phase_ff;
      byte_position_in = byte_position_ff;
      field_shift_in   = field_shift_ff;
      name_length_in   = name_length_ff;
      bytes_left_in    = bytes_left_ff;
      key_index_in     = key_index_ff;
      if (req_data.opcode == OP_START) begin
         byte_position_in = 3'd0;
         field_shift_in   = 64'd0;
         name_length_in   = '0;
         bytes_left_in    = 64'd0;
         key_index_in     = 4'd0;
         phase_in         = (payload_len_ff < 32'd4) ? PH_IDLE : PH_NAMELEN;
      end else if (active) begin
         if (key_eff_len != 5'd0) begin
            key_index_in = key_after;
         end
         case (phase_ff)
            PH_NAMELEN: begin
               field_shift_in   = field_next;
               byte_position_in = byte_position_ff + 3'd1;
               if (byte_position_ff == 3'd3) begin
                  byte_position_in = 3'd0;
                  if (name_bad) begin
                     phase_in = PH_IDLE;
                  end else begin
                     name_length_in = name_val[NAME_W-1:0];
                     bytes_left_in  = {32'd0, name_val};
                     field_shift_in = 64'd0;
                     phase_in       = PH_NAME;
                  end
               end
            end
            PH_NAME: begin
               bytes_left_in = bytes_left_ff - 64'd1;
               if (bytes_left_ff == 64'd1) begin
                  phase_in = PH_SECLEN;
               end
            end
            PH_SECLEN: begin
               field_shift_in   = field_next;
               byte_position_in = byte_position_ff + 3'd1;
               if (byte_position_ff == 3'd7) begin
                  byte_position_in = 3'd0;
                  if (sec_trunc) begin
                     phase_in = PH_IDLE;
                  end else begin
                     bytes_left_in  = field_next;
                     field_shift_in = 64'd0;
                     phase_in       = (field_next == 64'd0) ? PH_DONE : PH_SECRET;
                  end
               end
            end
            PH_SECRET: begin
               bytes_left_in = bytes_left_ff - 64'd1;
               if (bytes_left_ff == 64'd1) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // result of the current item
   always_comb begin
      res_valid    = 1'b0;
      res.kind     = KIND_NAME;
      res.out_byte = 8'd0;
      res.last     = 1'b0;
      if (req_data.opcode == OP_START) begin
         if (payload_len_ff < 32'd4) begin
            res_valid = 1'b1;
            res.kind  = KIND_SHORT;
         end
      end else begin
         case (phase_ff)
            PH_NAMELEN: begin
               if (byte_position_ff == 3'd3 && name_bad) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_BADNAME;
               end
            end
            PH_NAME: begin
               res_valid    = 1'b1;
               res.kind     = KIND_NAME;
               res.out_byte = plain;
               res.last     = (bytes_left_ff == 64'd1);
            end
            PH_SECLEN: begin
               if (byte_position_ff == 3'd7) begin
                  if (sec_trunc) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_TRUNC;
                  end else if (field_next == 64'd0) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_EMPTY;
                  end
               end
            end
            PH_SECRET: begin
               res_valid    = 1'b1;
               res.kind     = KIND_SECRET;
               res.out_byte = plain;
               res.last     = (bytes_left_ff == 64'd1);
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_enable_ff <= 1'b0;
         key_len_ff        <= 5'd0;
         key_bytes_ff      <= 128'd0;
         payload_len_ff    <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DECRYPT_ENABLE: decrypt_enable_ff     <= csr_wdata[0];
            CSR_KEY_LEN:        key_len_ff            <= csr_wdata[4:0];
            CSR_KEY_BYTES_LOW:  key_bytes_ff[63:0]    <= csr_wdata;
            CSR_KEY_BYTES_HIGH: key_bytes_ff[127:64]  <= csr_wdata;
            CSR_PAYLOAD_LEN:    payload_len_ff        <= csr_wdata[31:0];
            default:            payload_len_ff        <= payload_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         byte_position_ff <= 3'd0;
         field_shift_ff   <= 64'd0;
         name_length_ff   <= '0;
         bytes_left_ff    <= 64'd0;
         key_index_ff     <= 4'd0;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         byte_position_ff <= byte_position_in;
         field_shift_ff   <= field_shift_in;
         name_length_ff   <= name_length_in;
         bytes_left_ff    <= bytes_left_in;
         key_index_ff     <= key_index_in;
      end
   end

   // result register refills in the cycle it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         rsp_data_ff <= res;
      end
   end

   a_last_on_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last |->
         (rsp_data_ff.kind == KIND_NAME || rsp_data_ff.kind == KIND_SECRET))
      else $error("last set on a status beat");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NAME || phase_ff == PH_SECRET) |-> bytes_left_ff != 64'd0)
      else $error("byte phase with nothing left to send");

   a_name_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NAME || phase_ff == PH_SECLEN || phase_ff == PH_SECRET) |->
         (32'(name_length_ff) <= 32'(NameMax) && name_length_ff != '0))
      else $error("name length out of range past the length field");

   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.opcode == OP_START |=>
         (phase_ff == PH_IDLE || phase_ff == PH_NAMELEN))
      else $error("start item left parser in wrong phase");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("input stalled with no result pending");

endmodule
